// File: src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked while out of reset
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked while out of reset
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: src/rpw_pkg.sv
package rpw_pkg;

  localparam int COORD_BITS = 12;
  localparam int COLOR_BITS = 24;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  typedef enum logic {
    REQ_TICK  = 1'b0,
    REQ_START = 1'b1
  } req_kind_t;

  typedef enum logic [2:0] {
    SEG_ROW_A = 3'd0,
    SEG_ROW_B = 3'd1,
    SEG_COL_A = 3'd2,
    SEG_COL_B = 3'd3,
    SEG_LEFT  = 3'd4,
    SEG_SPAN  = 3'd5,
    SEG_RIGHT = 3'd6
  } seg_t;

  typedef struct packed {
    logic   req_type;
    coord_t corner0_x;
    coord_t corner0_y;
    coord_t corner1_x;
    coord_t corner1_y;
    logic   fill_mode;
    color_t border_color;
    color_t fill_color;
  } req_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   last_pixel;
  } pix_t;

endpackage

// File: src/rect_pixel_walker.sv
// a start, or a tick while a shape is in progress, loads its pixel into the result
//   register when it is accepted; ticks while idle load nothing
// throughput: one pixel per clock while pix_ready is high; walk steps once per pixel
// req_ready is high whenever the result register is empty or being drained
// reset (rst, synchronous): idle, result register empty, ticks ignored until a start
`include "assert_macros.svh"

module rect_pixel_walker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  rpw_pkg::req_t req,
  output logic          pix_valid,
  input  logic          pix_ready,
  output rpw_pkg::pix_t pix_data
);

  localparam int CB = rpw_pkg::COORD_BITS;

  // walk state, held across beats
  logic            busy, busy_next;
  logic            filled;
  rpw_pkg::seg_t   segment, segment_next;
  rpw_pkg::coord_t walk_x, walk_x_next;
  rpw_pkg::coord_t walk_y, walk_y_next;
  // latched shape: corners that the outline walk revisits, and the bounds
  rpw_pkg::coord_t x0, x1, y1;
  rpw_pkg::coord_t xmin, ymin, xmax, ymax;
  rpw_pkg::color_t border, fill;

  // current view: fresh from the request on a start, else the held state
  logic            start;
  logic            c_filled;
  rpw_pkg::seg_t   c_seg;
  rpw_pkg::coord_t c_wx, c_wy;
  rpw_pkg::coord_t c_x0, c_x1, c_y1;
  rpw_pkg::coord_t c_xmin, c_ymin, c_xmax, c_ymax;
  rpw_pkg::color_t c_border, c_fill;

  logic          req_fire;
  logic          emit;
  logic          more;
  rpw_pkg::pix_t pix_next;

  assign req_ready = !pix_valid || pix_ready;
  assign req_fire  = req_valid && req_ready;
  assign start     = req.req_type == rpw_pkg::REQ_START;
  assign emit      = req_fire && (start || busy);

  // select the starting point of the shape or carry on the current walk
  always_comb begin
    if (start) begin
      c_x0     = req.corner0_x;
      c_x1     = req.corner1_x;
      c_y1     = req.corner1_y;
      c_xmin   = (req.corner0_x < req.corner1_x) ? req.corner0_x : req.corner1_x;
      c_xmax   = (req.corner0_x < req.corner1_x) ? req.corner1_x : req.corner0_x;
      c_ymin   = (req.corner0_y < req.corner1_y) ? req.corner0_y : req.corner1_y;
      c_ymax   = (req.corner0_y < req.corner1_y) ? req.corner1_y : req.corner0_y;
      c_filled = req.fill_mode;
      c_border = req.border_color;
      c_fill   = req.fill_color;
      c_seg    = rpw_pkg::SEG_ROW_A;
      c_wx     = c_xmin;
      // outline walks the first row at corner0 y, filled at the top
      c_wy     = req.fill_mode ? c_ymin : req.corner0_y;
    end else begin
      c_x0     = x0;
      c_x1     = x1;
      c_y1     = y1;
      c_xmin   = xmin;
      c_xmax   = xmax;
      c_ymin   = ymin;
      c_ymax   = ymax;
      c_filled = filled;
      c_border = border;
      c_fill   = fill;
      c_seg    = segment;
      c_wx     = walk_x;
      c_wy     = walk_y;
    end
  end

  // next walk position
  always_comb begin
    logic [CB:0] wx_p1, wy_p1, xmin_p2, ymin_p2;
    wx_p1   = {1'b0, c_wx} + (CB+1)'(1);
    wy_p1   = {1'b0, c_wy} + (CB+1)'(1);
    xmin_p2 = {1'b0, c_xmin} + (CB+1)'(2);
    ymin_p2 = {1'b0, c_ymin} + (CB+1)'(2);
    more         = 1'b1;
    segment_next = c_seg;
    walk_x_next  = c_wx;
    walk_y_next  = c_wy;
    case (c_seg)
      rpw_pkg::SEG_ROW_A, rpw_pkg::SEG_ROW_B: begin
        if (c_wx < c_xmax) begin
          walk_x_next = wx_p1[CB-1:0];
        end else if (c_seg == rpw_pkg::SEG_ROW_A && c_ymin != c_ymax) begin
          segment_next = rpw_pkg::SEG_ROW_B;
          walk_x_next  = c_xmin;
          walk_y_next  = c_filled ? c_ymax : c_y1;
        end else if (c_filled) begin
          // inner rows only when at least one row lies between the edges
          if ({1'b0, c_ymax} >= ymin_p2) begin
            segment_next = rpw_pkg::SEG_LEFT;
            walk_x_next  = c_xmin;
            walk_y_next  = c_ymin + rpw_pkg::coord_t'(1);
          end else begin
            more = 1'b0;
          end
        end else begin
          segment_next = rpw_pkg::SEG_COL_A;
          walk_x_next  = c_x0;
          walk_y_next  = c_ymin;
        end
      end
      rpw_pkg::SEG_COL_A: begin
        if (c_wy < c_ymax) begin
          walk_y_next = wy_p1[CB-1:0];
        end else begin
          segment_next = rpw_pkg::SEG_COL_B;
          walk_x_next  = c_x1;
          walk_y_next  = c_ymin;
        end
      end
      rpw_pkg::SEG_COL_B: begin
        if (c_wy < c_ymax) begin
          walk_y_next = wy_p1[CB-1:0];
        end else begin
          more = 1'b0;
        end
      end
      rpw_pkg::SEG_LEFT: begin
        if ({1'b0, c_xmax} >= xmin_p2) begin
          segment_next = rpw_pkg::SEG_SPAN;
          walk_x_next  = c_xmin + rpw_pkg::coord_t'(1);
        end else begin
          segment_next = rpw_pkg::SEG_RIGHT;
          walk_x_next  = c_xmax;
        end
      end
      rpw_pkg::SEG_SPAN: begin
        if (wx_p1 < {1'b0, c_xmax}) begin
          walk_x_next = wx_p1[CB-1:0];
        end else begin
          segment_next = rpw_pkg::SEG_RIGHT;
          walk_x_next  = c_xmax;
        end
      end
      rpw_pkg::SEG_RIGHT: begin
        if (wy_p1 < {1'b0, c_ymax}) begin
          segment_next = rpw_pkg::SEG_LEFT;
          walk_x_next  = c_xmin;
          walk_y_next  = wy_p1[CB-1:0];
        end else begin
          more = 1'b0;
        end
      end
      default: begin
        more = 1'b0;
      end
    endcase
    busy_next = more;
  end

  // pixel for this beat
  always_comb begin
    pix_next.pixel_x     = c_wx;
    pix_next.pixel_y     = c_wy;
    pix_next.pixel_color = (c_seg == rpw_pkg::SEG_SPAN) ? c_fill : c_border;
    pix_next.last_pixel  = !more;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      segment   <= rpw_pkg::SEG_ROW_A;
      pix_valid <= 1'b0;
    end else begin
      if (emit) begin
        busy      <= busy_next;
        segment   <= segment_next;
        pix_valid <= 1'b1;
      end else if (pix_ready) begin
        pix_valid <= 1'b0;
      end
    end
  end

  // walk position, shape and result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      walk_x   <= walk_x_next;
      walk_y   <= walk_y_next;
      pix_data <= pix_next;
    end
    if (req_fire && start) begin
      x0     <= c_x0;
      x1     <= c_x1;
      y1     <= c_y1;
      xmin   <= c_xmin;
      xmax   <= c_xmax;
      ymin   <= c_ymin;
      ymax   <= c_ymax;
      filled <= c_filled;
      border <= c_border;
      fill   <= c_fill;
    end
  end

  // a tick with no shape in progress leaves the result register empty
  `ASSERT_NXT(a_idle_tick_no_pix, clk, rst, req_fire && !start && !busy, !pix_valid)
  // every start and every tick of a live shape loads a pixel
  `ASSERT_NXT(a_emit_loads_pix, clk, rst, emit, pix_valid)
  // inner-row segments only occur for filled shapes
  `ASSERT_IMP(a_inner_needs_fill, clk, rst,
    busy && (segment == rpw_pkg::SEG_LEFT || segment == rpw_pkg::SEG_SPAN ||
    segment == rpw_pkg::SEG_RIGHT), filled)
  // the walk never leaves the bounding box
  `ASSERT_IMP(a_walk_in_box, clk, rst, busy,
    walk_x >= xmin && walk_x <= xmax && walk_y >= ymin && walk_y <= ymax)

endmodule
